[src/bsa_pkg.sv]
// Shared codes and field widths of the bitmap slot allocator.
`timescale 1ns / 1ps

package bsa_pkg;

    localparam int SLOT_FW  = 6;
    localparam int COUNT_FW = 7;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

endpackage

[src/bsa_scan.sv]
// Shared word unit: find the lowest clear bit or test one bit, and build the updated word.
`timescale 1ns / 1ps

module bsa_scan #(
    parameter int WORD_BITS = 32,
    parameter int BW        = 5
) (
    input  logic                 i_mode,
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [WORD_BITS-1:0] i_mask,
    input  logic [BW-1:0]        i_bit,
    output logic                 o_hit,
    output logic [BW-1:0]        o_bit,
    output logic [WORD_BITS-1:0] o_word
);

    logic [WORD_BITS-1:0] clear_bits;
    logic [WORD_BITS-1:0] onehot;
    logic [BW-1:0]        first;
    logic [BW-1:0]        sel;

    always_comb begin
        clear_bits = ~i_word & i_mask;
        first = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (clear_bits[i]) begin
                first = BW'(i);
            end
        end
        sel    = (i_mode == bsa_pkg::MODE_FREE) ? i_bit : first;
        onehot = {{(WORD_BITS-1){1'b0}}, 1'b1} << sel;
        if (i_mode == bsa_pkg::MODE_FREE) begin
            o_hit  = |(i_word & onehot);
            o_word = i_word & ~onehot;
        end else begin
            o_hit  = |clear_bits;
            o_word = i_word | onehot;
        end
        o_bit = sel;
    end

endmodule

[src/bsa_store.sv]
// Bitmap word memory with per-word valid bits and a registered read port.
`timescale 1ns / 1ps

module bsa_store #(
    parameter int WORD_BITS  = 32,
    parameter int WORD_COUNT = 2,
    parameter int AW         = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [WORD_BITS-1:0] o_rd_data,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [WORD_BITS-1:0] i_wr_data
);

    logic [WORD_BITS-1:0] r_mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] r_vld;
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rvld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rvld ? r_rdata : '0;

endmodule

[src/bitmap_slot_allocator_top.sv]
// Bitmap slot allocator: usage
//   Input channel (i_in_valid / o_in_stall) takes one word: i_mode selects allocate (0)
//   or free (1) of i_slot_to_free. The block stalls its input from acceptance until
//   the result is loaded into the output register.
//   Output channel (o_out_valid / i_out_stall) gives one word per input: the granted
//   or echoed slot, status (ok, no free slot, bad free), any_free, any_used, free count.
//   The bitmap memory is read one word per cycle, from word 0 at acceptance. An item
//   loads its result once the scan reaches the word that holds its slot; allocate with no
//   free slot loads after the last word, and an out-of-range free at word 0. The next word
//   is accepted the cycle after, so only one word is in progress at a time.
//   A stalled result holds in the output register; the block still accepts one new
//   word and finishes it, then waits in its last step until the register frees.
//   Reset (synchronous, active low) clears the per-word valid bits, so every slot
//   reads free at once, sets the free count to SLOT_COUNT and drops any held result.
`timescale 1ns / 1ps

module bitmap_slot_allocator_top #(
    parameter int SLOT_COUNT = 64,
    parameter int WORD_BITS  = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_mode,
    input  logic [5:0] i_slot_to_free,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [5:0] o_slot_index,
    output logic [1:0] o_status,
    output logic       o_any_free,
    output logic       o_any_used,
    output logic [6:0] o_free_count
);

    localparam int WORD_COUNT = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int BW = $clog2(WORD_BITS);
    localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int PW = (AW + BW > bsa_pkg::SLOT_FW) ? AW + BW : bsa_pkg::SLOT_FW;
    localparam int RW = PW + 1;
    localparam int FW = $clog2(SLOT_COUNT + 1);
    localparam int OW = (FW > bsa_pkg::COUNT_FW) ? FW : bsa_pkg::COUNT_FW;
    localparam int LAST_N = SLOT_COUNT - (WORD_COUNT - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_MASK =
        {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_N);
    localparam logic [AW-1:0] LAST_ADDR = AW'(WORD_COUNT - 1);

    typedef enum logic [0:0] {
        S_IDLE,
        S_EVAL
    } t_state;

    t_state         r_state;
    logic           r_mode;
    logic [5:0]     r_req;
    logic           r_bad;
    logic [AW-1:0]  r_addr;
    logic [PW-1:0]  r_base;
    logic [FW-1:0]  r_count;
    logic           r_ovalid;
    logic [5:0]     r_oslot;
    logic [1:0]     r_ostatus;
    logic           r_ofree;
    logic           r_oused;
    logic [6:0]     r_ocount;

    logic                 in_acc;
    logic                 out_free;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] mask;
    logic [RW-1:0]        diff;
    logic                 in_word;
    logic                 hit;
    logic [BW-1:0]        hit_bit;
    logic [WORD_BITS-1:0] new_word;
    logic                 done;
    logic                 advance;
    logic                 wr_ok;
    logic                 commit;
    logic [PW-1:0]        slot_sum;
    logic [5:0]           n_slot;
    logic [1:0]           n_status;
    logic [FW-1:0]        n_count;
    logic [OW-1:0]        count_ext;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;
    assign mask     = (r_addr == LAST_ADDR) ? LAST_MASK : {WORD_BITS{1'b1}};
    assign diff     = RW'(r_req) - RW'(r_base);
    assign in_word  = diff < RW'(WORD_BITS);

    bsa_scan #(
        .WORD_BITS (WORD_BITS),
        .BW        (BW)
    ) u_scan (
        .i_mode (r_mode),
        .i_word (rd_data),
        .i_mask (mask),
        .i_bit  (diff[BW-1:0]),
        .o_hit  (hit),
        .o_bit  (hit_bit),
        .o_word (new_word)
    );

    always_comb begin
        done     = 1'b0;
        advance  = 1'b0;
        wr_ok    = 1'b0;
        n_slot   = r_req;
        n_status = bsa_pkg::ST_OK;
        n_count  = r_count;
        slot_sum = r_base + PW'(hit_bit);
        if (r_state == S_EVAL) begin
            if (r_mode == bsa_pkg::MODE_ALLOC) begin
                if (hit) begin
                    done    = 1'b1;
                    wr_ok   = 1'b1;
                    n_slot  = slot_sum[5:0];
                    n_count = r_count - FW'(1);
                end else if (r_addr == LAST_ADDR) begin
                    done     = 1'b1;
                    n_slot   = '0;
                    n_status = bsa_pkg::ST_FULL;
                end else begin
                    advance = 1'b1;
                end
            end else begin
                if (r_bad) begin
                    done     = 1'b1;
                    n_status = bsa_pkg::ST_BAD;
                end else if (!in_word) begin
                    advance = 1'b1;
                end else if (hit) begin
                    done    = 1'b1;
                    wr_ok   = 1'b1;
                    n_count = r_count + FW'(1);
                end else begin
                    done     = 1'b1;
                    n_status = bsa_pkg::ST_BAD;
                end
            end
        end
        commit    = done && out_free;
        count_ext = OW'(n_count);
        rd_en     = in_acc || advance;
        rd_addr   = in_acc ? '0 : r_addr + AW'(1);
    end

    bsa_store #(
        .WORD_BITS  (WORD_BITS),
        .WORD_COUNT (WORD_COUNT),
        .AW         (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (commit && wr_ok),
        .i_wr_addr (r_addr),
        .i_wr_data (new_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= FW'(SLOT_COUNT);
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_EVAL;
                        r_mode  <= i_mode;
                        r_req   <= i_slot_to_free;
                        r_bad   <= RW'(i_slot_to_free) >= RW'(SLOT_COUNT);
                        r_addr  <= '0;
                        r_base  <= '0;
                    end
                end
                S_EVAL: begin
                    if (advance) begin
                        r_addr <= rd_addr;
                        r_base <= r_base + PW'(WORD_BITS);
                    end else if (commit) begin
                        r_state <= S_IDLE;
                        r_count <= n_count;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (commit) begin
                r_ovalid  <= 1'b1;
                r_oslot   <= n_slot;
                r_ostatus <= n_status;
                r_ofree   <= n_count != '0;
                r_oused   <= n_count != FW'(SLOT_COUNT);
                r_ocount  <= count_ext[6:0];
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_in_stall   = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid  = r_ovalid;
    assign o_slot_index = r_oslot;
    assign o_status     = r_ostatus;
    assign o_any_free   = r_ofree;
    assign o_any_used   = r_oused;
    assign o_free_count = r_ocount;

endmodule

[bench/tb_bitmap_slot_allocator_top.sv]
// Self-checking bench for bitmap_slot_allocator_top: queued requests, live model, scoreboard.
`timescale 1ns / 1ps

module tb_bitmap_slot_allocator_top;

    localparam int NSLOTS      = 64;
    localparam int WBITS       = 32;
    localparam int NWORDS      = (NSLOTS + WBITS - 1) / WBITS;
    localparam int SLOT_W      = bsa_pkg::SLOT_FW;
    localparam int COUNT_W     = bsa_pkg::COUNT_FW;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_LEN    = 80;

    typedef struct packed {
        logic              mode;
        logic [SLOT_W-1:0] slot;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [1:0]         status;
        logic               any_free;
        logic               any_used;
        logic [COUNT_W-1:0] free_count;
    } t_grant;

    typedef struct packed {
        logic [NWORDS-1:0][WBITS-1:0] used;
        logic [COUNT_W-1:0]           nfree;
    } t_store;

    typedef struct packed {
        t_store nxt;
        t_grant res;
    } t_step;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              i_mode = bsa_pkg::MODE_ALLOC;
    logic [SLOT_W-1:0] i_slot_to_free = '0;
    logic              i_out_stall = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [5:0]        o_slot_index;
    logic [1:0]        o_status;
    logic              o_any_free;
    logic              o_any_used;
    logic [6:0]        o_free_count;

    t_req   pending_words[$];
    t_grant expected_grants[$];
    t_store live_store;
    t_store plan_store;

    int send_idle_pct = 32;
    int recv_idle_pct = 88;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int fail_count = 0;
    int cycles = 0;
    int planned = 0;
    int n_granted = 0;
    int n_full = 0;
    int n_freed = 0;
    int n_bad = 0;

    bitmap_slot_allocator_top #(
        .SLOT_COUNT(NSLOTS),
        .WORD_BITS (WBITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_slot_to_free(i_slot_to_free),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_slot_index  (o_slot_index),
        .o_status      (o_status),
        .o_any_free    (o_any_free),
        .o_any_used    (o_any_used),
        .o_free_count  (o_free_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_store empty_store();
        t_store s;
        s.used  = '0;
        s.nfree = COUNT_W'(NSLOTS);
        return s;
    endfunction

    function automatic t_step step_store(t_store s, logic mode, logic [SLOT_W-1:0] req);
        t_step r;
        logic  found;
        int    w;
        int    b;
        r.nxt        = s;
        r.res.slot   = '0;
        r.res.status = bsa_pkg::ST_OK;
        found        = 1'b0;
        if (mode == bsa_pkg::MODE_ALLOC) begin
            for (w = 0; w < NWORDS; w++) begin
                for (b = 0; b < WBITS; b++) begin
                    if (!found && (w * WBITS + b) < NSLOTS && !s.used[w][b]) begin
                        found            = 1'b1;
                        r.nxt.used[w][b] = 1'b1;
                        r.res.slot       = SLOT_W'(w * WBITS + b);
                        if (r.nxt.nfree > 0) r.nxt.nfree = r.nxt.nfree - COUNT_W'(1);
                    end
                end
            end
            if (!found) r.res.status = bsa_pkg::ST_FULL;
        end else begin
            r.res.slot = req;
            if (int'(req) >= NSLOTS || !s.used[req / WBITS][req % WBITS]) begin
                r.res.status = bsa_pkg::ST_BAD;
            end else begin
                r.nxt.used[req / WBITS][req % WBITS] = 1'b0;
                if (r.nxt.nfree < NSLOTS) r.nxt.nfree = r.nxt.nfree + COUNT_W'(1);
            end
        end
        r.res.any_free   = (r.nxt.used != '1);
        r.res.any_used   = (r.nxt.used != '0);
        r.res.free_count = r.nxt.nfree;
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] pick_busy_slot(t_store s);
        int start;
        int k;
        int idx;
        start = $urandom_range(NSLOTS - 1);
        for (k = 0; k < NSLOTS; k++) begin
            idx = (start + k) % NSLOTS;
            if (s.used[idx / WBITS][idx % WBITS]) return SLOT_W'(idx);
        end
        return SLOT_W'(start);
    endfunction

    task automatic queue_word(logic mode, logic [SLOT_W-1:0] slot);
        t_step st;
        t_req  r;
        r.mode = mode;
        r.slot = slot;
        pending_words.push_back(r);
        st         = step_store(plan_store, mode, slot);
        plan_store = st.nxt;
        planned++;
    endtask

    task automatic queue_phase(int n);
        int target;
        int kind;
        int len;
        int k;
        target = planned + n;
        for (k = 0; k < NSLOTS + 3; k++) queue_word(bsa_pkg::MODE_ALLOC, SLOT_W'($urandom));
        while (planned < target) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                len = $urandom_range(1, 24);
                for (k = 0; k < len; k++) queue_word(bsa_pkg::MODE_ALLOC, SLOT_W'($urandom));
            end else if (kind < 82) begin
                len = $urandom_range(1, 24);
                for (k = 0; k < len; k++)
                    queue_word(bsa_pkg::MODE_FREE, pick_busy_slot(plan_store));
            end else begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++) queue_word(1'($urandom), SLOT_W'($urandom));
            end
        end
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || i_in_valid || expected_grants.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic check_field(string name, int exp_v, int got_v);
        if (exp_v != got_v) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, exp_v, got_v);
            fail_count++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        t_step st;
        t_req  r;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                st         = step_store(live_store, i_mode, i_slot_to_free);
                live_store = st.nxt;
                expected_grants.push_back(st.res);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    r = pending_words.pop_front();
                    i_mode         <= r.mode;
                    i_slot_to_free <= r.slot;
                    i_in_valid     <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_grant g;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_grants.size() == 0) begin
                $display("%0t unexpected word: expected none actual slot %0d status %0d",
                         $realtime, o_slot_index, o_status);
                fail_count++;
            end else begin
                g = expected_grants.pop_front();
                check_field("slot_index", g.slot, o_slot_index);
                check_field("status", g.status, o_status);
                check_field("any_free", g.any_free, o_any_free);
                check_field("any_used", g.any_used, o_any_used);
                check_field("free_count", g.free_count, o_free_count);
                case (g.status)
                    bsa_pkg::ST_FULL: n_full++;
                    bsa_pkg::ST_BAD:  n_bad++;
                    default: begin
                    end
                endcase
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall && i_rst_n) begin
            if (i_mode == bsa_pkg::MODE_ALLOC) n_granted++;
            else n_freed++;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, expected_grants.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        live_store = empty_store();
        plan_store = empty_store();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_word(bsa_pkg::MODE_ALLOC, 6'h3f);
        queue_word(bsa_pkg::MODE_ALLOC, 6'h00);
        queue_word(bsa_pkg::MODE_FREE,  6'h00);
        queue_word(bsa_pkg::MODE_FREE,  6'h00);
        queue_word(bsa_pkg::MODE_FREE,  6'h3f);
        queue_word(bsa_pkg::MODE_FREE,  6'h20);
        queue_word(bsa_pkg::MODE_FREE,  6'h1f);
        queue_word(bsa_pkg::MODE_ALLOC, 6'h15);
        queue_word(bsa_pkg::MODE_ALLOC, 6'h2a);
        queue_word(bsa_pkg::MODE_FREE,  6'h01);
        queue_word(bsa_pkg::MODE_ALLOC, 6'h00);
        queue_word(bsa_pkg::MODE_FREE,  6'h2a);
        queue_word(bsa_pkg::MODE_FREE,  6'h00);
        queue_word(bsa_pkg::MODE_FREE,  6'h01);
        queue_word(bsa_pkg::MODE_FREE,  6'h01);
        queue_word(bsa_pkg::MODE_ALLOC, 6'h3f);
        queue_word(bsa_pkg::MODE_FREE,  6'h00);
        queue_word(bsa_pkg::MODE_FREE,  6'h15);
        drain();

        send_idle_pct = 32;
        recv_idle_pct = 88;
        queue_phase(250);
        drain();

        send_idle_pct = 88;
        recv_idle_pct = 32;
        queue_phase(250);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asks++;
        queue_phase(250);
        drain();

        repeat (20) @(posedge i_clk);
        $display("covered %0d words: %0d allocate, %0d free requests", planned, n_granted, n_freed);
        $display("  store-full refusals %0d, rejected frees %0d, mismatches %0d",
                 n_full, n_bad, fail_count);
        if (fail_count == 0 && expected_grants.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[sim.f]
src/bsa_pkg.sv
src/bsa_scan.sv
src/bsa_store.sv
src/bitmap_slot_allocator_top.sv
bench/tb_bitmap_slot_allocator_top.sv
